>>> sv/dfp_pkg.sv
package dfp_pkg;

  localparam int unsigned FILTER_SAMPLES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;

  localparam logic [15:0] MIN_DISTANCE_RST  = 16'd30;
  localparam logic [15:0] MAX_DISTANCE_RST  = 16'd4500;
  localparam logic [15:0] MAX_STEP_RST      = 16'd500;
  localparam logic [31:0] FAULT_TIMEOUT_RST = 32'd1000;

  typedef enum logic [1:0] {
    REG_MIN_DISTANCE  = 2'd0,
    REG_MAX_DISTANCE  = 2'd1,
    REG_MAX_STEP      = 2'd2,
    REG_FAULT_TIMEOUT = 2'd3
  } dfp_reg_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_UPDATE = 1'b1
  } dfp_kind_e;

  typedef enum logic [1:0] {
    STATUS_NO_DATA = 2'd0,
    STATUS_OK      = 2'd1,
    STATUS_FAULT   = 2'd2
  } dfp_status_e;

  typedef struct packed {
    logic [15:0] min_distance;
    logic [15:0] max_distance;
    logic [15:0] max_step;
    logic [31:0] fault_timeout;
  } dfp_cfg_t;

  // sample events carry the distance in data[15:0], updates carry now_ms
  typedef struct packed {
    dfp_kind_e   kind;
    logic [31:0] data;
  } dfp_evt_t;

  typedef struct packed {
    logic        ever_valid;
    logic [31:0] last_valid_time;
    dfp_status_e sensor_status;
    logic [15:0] raw_mm;
    logic [15:0] filtered_mm;
  } dfp_result_t;

endpackage

>>> sv/dfp_front.sv
module dfp_front
  import dfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,  // rx_byte [7:0], now_ms [39:8]
  input  logic [0:0]  s_tuser_i,  // cmd [0]
  input  dfp_cfg_t    cfg_i,
  input  logic        evt_full_i,
  output logic        evt_push_o,
  output dfp_evt_t    evt_o
);

  logic [1:0] pos_q, pos_d;
  logic [7:0] hi_q, hi_d;
  logic [7:0] lo_q, lo_d;

  logic        accept;
  logic [7:0]  rx_byte;
  logic [7:0]  csum;
  logic [15:0] dist_mm;
  logic        good;

  assign s_tready_o = !evt_full_i;
  assign accept     = s_tvalid_i && !evt_full_i;
  assign rx_byte    = s_tdata_i[7:0];
  assign csum       = HEADER_BYTE + hi_q + lo_q;
  assign dist_mm    = {hi_q, lo_q};
  assign good       = (csum == rx_byte) && (dist_mm >= cfg_i.min_distance)
                      && (dist_mm <= cfg_i.max_distance);

  always_comb begin
    pos_d      = pos_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    evt_push_o = 1'b0;
    evt_o.kind = KIND_UPDATE;
    evt_o.data = s_tdata_i[39:8];
    if (accept) begin
      if (s_tuser_i[0] == KIND_UPDATE) begin
        evt_push_o = 1'b1;
      end else begin
        case (pos_q)
          2'd0: if (rx_byte == HEADER_BYTE) pos_d = 2'd1;
          2'd1: begin
            hi_d  = rx_byte;
            pos_d = 2'd2;
          end
          2'd2: begin
            lo_d  = rx_byte;
            pos_d = 2'd3;
          end
          default: begin
            // checksum byte: bad frames are dropped here
            pos_d      = 2'd0;
            evt_push_o = good;
            evt_o.kind = KIND_SAMPLE;
            evt_o.data = {16'd0, dist_mm};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      hi_q  <= 8'd0;
      lo_q  <= 8'd0;
    end else begin
      pos_q <= pos_d;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
    end
  end

endmodule

>>> sv/dfp_queue.sv
module dfp_queue
  import dfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dfp_evt_t evt_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output dfp_evt_t evt_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  dfp_evt_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign evt_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= evt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/dfp_back.sv
module dfp_back
  import dfp_pkg::*;
#(
  parameter int unsigned FILTER_SAMPLES = FILTER_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dfp_cfg_t    cfg_i,
  input  logic        evt_valid_i,
  input  dfp_evt_t    evt_i,
  output logic        evt_pop_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output dfp_result_t m_result_o
);

  localparam int unsigned N      = FILTER_SAMPLES;
  localparam int unsigned IDX_W  = $clog2(N);
  localparam int unsigned CNT_W  = $clog2(N + 1);
  localparam int unsigned SUM_W  = 16 + $clog2(N);
  localparam int unsigned DIV    = N - 2;
  localparam int unsigned DIV_L  = $clog2(DIV);
  localparam int unsigned SH     = SUM_W + DIV_L;
  localparam int unsigned PROD_W = 2 * SUM_W + 1;
  // rounded-up reciprocal: exact quotient for every dividend below 2**SUM_W
  localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(((64'd1 << SH) + DIV - 1) / DIV);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_TRIM  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_SCALE = 6'b010000,
    ST_STAT  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [15:0]       ring_q [N];
  logic [15:0]       ring_d [N];
  logic [IDX_W-1:0]  cursor_q, cursor_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [15:0]       raw_q, raw_d;
  logic [15:0]       filt_q, filt_d;
  logic [31:0]       stamp_q, stamp_d;
  logic              seen_q, seen_d;
  logic              fsu_q, fsu_d;
  logic [31:0]       now_q, now_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [15:0]       min_q, min_d;
  logic [15:0]       max_q, max_d;
  logic [SUM_W-1:0]  trim_q, trim_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              out_valid_q, out_valid_d;
  dfp_result_t       out_q, out_d;

  logic        full;
  logic [15:0] dist_mm;
  logic [15:0] step;
  logic [15:0] cur;
  logic [31:0] elapsed;
  dfp_status_e status;

  assign full       = (cnt_q == CNT_W'(N));
  assign dist_mm    = evt_i.data[15:0];
  assign step       = (dist_mm > filt_q) ? dist_mm - filt_q : filt_q - dist_mm;
  assign cur        = ring_q[idx_q];
  assign elapsed    = now_q - stamp_q;
  assign m_tvalid_o = out_valid_q;
  assign m_result_o = out_q;

  always_comb begin
    if (!seen_q) status = STATUS_NO_DATA;
    else if (elapsed >= cfg_i.fault_timeout) status = STATUS_FAULT;
    else if (filt_q == 16'd0) status = STATUS_NO_DATA;
    else status = STATUS_OK;
  end

  always_comb begin
    state_d     = state_q;
    ring_d      = ring_q;
    cursor_d    = cursor_q;
    cnt_d       = cnt_q;
    raw_d       = raw_q;
    filt_d      = filt_q;
    stamp_d     = stamp_q;
    seen_d      = seen_q;
    fsu_d       = fsu_q;
    now_d       = now_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    trim_d      = trim_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    evt_pop_o   = 1'b0;

    if (out_valid_q && m_tready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (evt_valid_i) begin
          evt_pop_o = 1'b1;
          if (evt_i.kind == KIND_SAMPLE) begin
            raw_d  = dist_mm;
            seen_d = 1'b1;
            fsu_d  = 1'b1;
            // a full ring with a nonzero filtered value rejects a jump too far from it
            if (!(full && filt_q != 16'd0 && step > cfg_i.max_step)) begin
              ring_d[cursor_q] = dist_mm;
              cursor_d = (cursor_q == IDX_W'(N - 1)) ? '0 : cursor_q + 1'b1;
              if (!full) cnt_d = cnt_q + 1'b1;
            end
          end else begin
            now_d = evt_i.data;
            fsu_d = 1'b0;
            if (fsu_q) stamp_d = evt_i.data;
            if (full) begin
              idx_d   = '0;
              sum_d   = '0;
              min_d   = 16'hFFFF;
              max_d   = 16'd0;
              state_d = ST_SCAN;
            end else begin
              if (fsu_q) filt_d = raw_q;
              state_d = ST_STAT;
            end
          end
        end
      end
      ST_SCAN: begin
        sum_d = sum_q + SUM_W'(cur);
        if (cur < min_q) min_d = cur;
        if (cur > max_q) max_d = cur;
        if (idx_q == IDX_W'(N - 1)) state_d = ST_TRIM;
        else idx_d = idx_q + 1'b1;
      end
      ST_TRIM: begin
        trim_d  = sum_q - SUM_W'(min_q) - SUM_W'(max_q);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = PROD_W'(trim_q) * PROD_W'(RECIP);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        filt_d  = prod_q[SH+15:SH];
        state_d = ST_STAT;
      end
      ST_STAT: begin
        // wait for the output register to drain
        if (!out_valid_q || m_tready_i) begin
          out_d.filtered_mm     = filt_q;
          out_d.raw_mm          = raw_q;
          out_d.sensor_status   = status;
          out_d.last_valid_time = stamp_q;
          out_d.ever_valid      = seen_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
    now_q  <= now_d;
    idx_q  <= idx_d;
    sum_q  <= sum_d;
    min_q  <= min_d;
    max_q  <= max_d;
    trim_q <= trim_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      cnt_q       <= '0;
      raw_q       <= 16'd0;
      filt_q      <= 16'd0;
      stamp_q     <= 32'd0;
      seen_q      <= 1'b0;
      fsu_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      cnt_q       <= cnt_d;
      raw_q       <= raw_d;
      filt_q      <= filt_d;
      stamp_q     <= stamp_d;
      seen_q      <= seen_d;
      fsu_q       <= fsu_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(N)) else $error("sample count beyond ring size");

  a_ring_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> cnt_q == '0) else $error("ring holds samples without a good frame");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_pop_o |-> state_q == ST_IDLE) else $error("event popped while busy");

  a_stat_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STAT && (!out_valid_q || m_tready_i)) |=> out_valid_q)
    else $error("result not loaded after status");

endmodule

>>> sv/distance_frame_parser_trimmed_filter.sv
// The parser never stalls byte transfers while the event queue has room.
// Update transfers: with the ring not yet full, an update passes through the event queue
// and the back end's status step into the output register; with a full ring the back end
// first walks over the sample ring, then trims, multiplies by the reciprocal and scales
// before the status step.
// rst_ni is asynchronous, active low: parser, ring count, filter state and registers reset.
module distance_frame_parser_trimmed_filter
  import dfp_pkg::*;
#(
  parameter int unsigned FILTER_SAMPLES = FILTER_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // rx_byte [7:0], now_ms [39:8]
  input  logic [0:0]  s_axis_tuser_i,  // cmd [0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // filtered_mm [15:0], raw_mm [31:16], sensor_status [33:32],
  // last_valid_time [65:34], ever_valid [66], zero [71:67]
  output logic [71:0] m_axis_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  dfp_cfg_t    cfg_q, cfg_d;
  dfp_reg_e    reg_sel;
  logic        cfg_wr;
  logic        evt_push, evt_full, evt_pop, evt_valid;
  dfp_evt_t    evt_in, evt_out;
  dfp_result_t result;

  assign pready_o = 1'b1;
  assign reg_sel  = dfp_reg_e'(paddr_i[3:2]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_MIN_DISTANCE:  cfg_d.min_distance  = pwdata_i[15:0];
        REG_MAX_DISTANCE:  cfg_d.max_distance  = pwdata_i[15:0];
        REG_MAX_STEP:      cfg_d.max_step      = pwdata_i[15:0];
        REG_FAULT_TIMEOUT: cfg_d.fault_timeout = pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_DISTANCE:  prdata_o = {16'd0, cfg_q.min_distance};
      REG_MAX_DISTANCE:  prdata_o = {16'd0, cfg_q.max_distance};
      REG_MAX_STEP:      prdata_o = {16'd0, cfg_q.max_step};
      REG_FAULT_TIMEOUT: prdata_o = cfg_q.fault_timeout;
      default:           prdata_o = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_distance  <= MIN_DISTANCE_RST;
      cfg_q.max_distance  <= MAX_DISTANCE_RST;
      cfg_q.max_step      <= MAX_STEP_RST;
      cfg_q.fault_timeout <= FAULT_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .cfg_i      (cfg_q),
    .evt_full_i (evt_full),
    .evt_push_o (evt_push),
    .evt_o      (evt_in)
  );

  dfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_push),
    .evt_i   (evt_in),
    .full_o  (evt_full),
    .pop_i   (evt_pop),
    .valid_o (evt_valid),
    .evt_o   (evt_out)
  );

  dfp_back #(
    .FILTER_SAMPLES (FILTER_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .evt_valid_i (evt_valid),
    .evt_i       (evt_out),
    .evt_pop_o   (evt_pop),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_result_o  (result)
  );

  assign m_axis_tdata_o = {5'd0, result};

endmodule
